>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every cycle out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

>>> hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// types and constants of the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOT_W        = 4;
    localparam int TABLE_SLOTS   = 1 << SLOT_W;
    localparam int KEY_W         = 31;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int SLOT_FIELD_W  = 4;
    localparam int PROBE_FIELD_W = 5;
    localparam int CMDQ_PTR_W    = 1;
    localparam int CMDQ_DEPTH    = 1 << CMDQ_PTR_W;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd0;
    localparam int               REQ_CLEAR_BIT = 1;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_CLEAR
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
    } cmd_t;

endpackage

>>> hdl/lpht_req_if.sv
// ----------------------------------------------------------------------------
// lpht_req_if
// request channel: operation code and key
// ----------------------------------------------------------------------------
interface lpht_req_if import lpht_pkg::*;;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);

endinterface

>>> hdl/lpht_res_if.sv
// ----------------------------------------------------------------------------
// lpht_res_if
// result channel: status, slot and probe count
// ----------------------------------------------------------------------------
interface lpht_res_if import lpht_pkg::*;;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [PROBE_FIELD_W-1:0] probes;

    modport source (output valid, output status, output slot, output probes, input ready);
    modport sink   (input valid, input status, input slot, input probes, output ready);

endinterface

>>> hdl/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front
// accepts requests, decodes the operation and the home slot into a command
// ----------------------------------------------------------------------------
module lpht_front import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpht_req_if.sink   req,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  logic       cmd_ready
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    op_t  op_dec;

    always_comb
    begin
        priority if (req.req_type[REQ_CLEAR_BIT])
        begin
            op_dec = OP_CLEAR;
        end
        else if (req.req_type == REQ_INSERT)
        begin
            op_dec = OP_INSERT;
        end
        else
        begin
            op_dec = OP_SEARCH;
        end
    end

    assign req.ready = !valid_reg || cmd_ready;

    always_comb
    begin
        valid_next = valid_reg && !cmd_ready;
        cmd_next   = cmd_reg;
        if (req.valid && req.ready)
        begin
            valid_next    = 1'b1;
            cmd_next.op   = op_dec;
            cmd_next.key  = req.key;
            cmd_next.home = req.key[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cmd_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

>>> hdl/lpht_cmd_q.sv
// ----------------------------------------------------------------------------
// lpht_cmd_q
// small command queue between the request decoder and the probe engine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpht_cmd_q import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W:0]   count_reg;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_CLK(a_count_bound, count_reg <= (CMDQ_PTR_W+1)'(CMDQ_DEPTH), "queue count overflow")

endmodule

>>> hdl/lpht_engine.sv
// ----------------------------------------------------------------------------
// lpht_engine
// probe engine: walks the table one slot a cycle, owns key memory and result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpht_engine import lpht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    lpht_res_if.source res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK
    } state_t;

    state_t                   state_reg,  state_next;
    op_t                      op_reg,     op_next;
    logic [KEY_W-1:0]         key_reg,    key_next;
    logic [SLOT_W-1:0]        idx_reg,    idx_next;
    logic [SLOT_W-1:0]        cnt_reg,    cnt_next;
    logic [TABLE_SLOTS-1:0]   used_reg,   used_next;
    logic                     used_q_reg, used_q_next;
    logic                     res_valid_reg,  res_valid_next;
    status_t                  res_status_reg, res_status_next;
    logic [SLOT_FIELD_W-1:0]  res_slot_reg,   res_slot_next;
    logic [PROBE_FIELD_W-1:0] res_probes_reg, res_probes_next;

    logic [KEY_W-1:0]  key_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]  key_q_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic              out_free;
    logic              hit;
    logic              last;
    logic              ins_hit;

    assign out_free  = !res_valid_reg || res.ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign rd_addr   = (state_reg == S_CHECK) ? idx_reg + 1'b1 : idx_reg;
    assign hit       = (op_reg == OP_INSERT) ? !used_q_reg
                                             : (used_q_reg && (key_q_reg == key_reg));
    assign last      = (cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign ins_hit   = (state_reg == S_CHECK) && (op_reg == OP_INSERT) && hit;
    assign mem_we    = ins_hit;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        used_q_next     = used_reg[rd_addr];
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_probes_next = res_probes_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd.op == OP_CLEAR)
                    begin
                        used_next       = '0;
                        res_valid_next  = 1'b1;
                        res_status_next = ST_CLEARED;
                        res_slot_next   = '0;
                        res_probes_next = '0;
                    end
                    else
                    begin
                        op_next    = cmd.op;
                        key_next   = cmd.key;
                        idx_next   = cmd.home;
                        cnt_next   = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        used_next[idx_reg] = 1'b1;
                        res_status_next    = ST_INSERTED;
                    end
                    else
                    begin
                        res_status_next = ST_FOUND;
                    end
                    res_valid_next  = 1'b1;
                    res_slot_next   = SLOT_FIELD_W'(idx_reg);
                    res_probes_next = PROBE_FIELD_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
                else if (last)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = (op_reg == OP_INSERT) ? ST_FULL : ST_ABSENT;
                    res_slot_next   = '0;
                    res_probes_next = PROBE_FIELD_W'(TABLE_SLOTS);
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            used_reg       <= '0;
            used_q_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_INSERTED;
            res_slot_reg   <= '0;
            res_probes_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            used_q_reg     <= used_q_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_probes_reg <= res_probes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[idx_reg] <= key_reg;
        end
        key_q_reg <= key_mem[rd_addr];
    end

    assign res.valid  = res_valid_reg;
    assign res.status = res_status_reg;
    assign res.slot   = res_slot_reg;
    assign res.probes = res_probes_reg;

    `ASSERT_IMPLY(a_probe_out_free, state_reg != S_IDLE, !res_valid_reg, "probe with result pending")
    `ASSERT_NEXT(a_clear_empties, cmd_valid && cmd_ready && cmd.op == OP_CLEAR, used_reg == '0, "clear left slots used")
    `ASSERT_NEXT(a_insert_fills, ins_hit, $countones(used_reg) == $past($countones(used_reg)) + 1, "insert did not fill one slot")

endmodule

>>> hdl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash table with linear probing: insert, search, clear
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req      in   req_type[1:0], key[30:0]
//  res      out  status[2:0], slot[3:0], probes[4:0]
//
//  insert and search pass a read state in the probe engine, then check one slot
//  per probe until a hit or all TABLE_SLOTS slots miss; clear is done in idle
//  one key memory read per probe
//  requests pass a decode register and a two-entry queue, so req keeps taking
//  transactions while the engine probes or a result waits on res until both fill
//  asynchronous reset empties every slot at once
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpht_req_if.sink   req,
    lpht_res_if.source res
);

    cmd_t dec_cmd;
    logic dec_valid;
    logic dec_ready;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    lpht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (dec_cmd),
        .cmd_valid (dec_valid),
        .cmd_ready (dec_ready)
    );

    lpht_cmd_q u_cmd_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (dec_valid),
        .push_ready (dec_ready),
        .push_cmd   (dec_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    lpht_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res       (res)
    );

endmodule

>>> bench/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// watches the request and result channels of the hash table, keeps a shadow
// copy of the slots, predicts status, slot and probe count of every request
// and compares each result transaction with the oldest prediction
// ----------------------------------------------------------------------------
module lpht_checker import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lpht_req_if  req,
    lpht_res_if  res,
    output int   fail_count,
    output int   pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [PROBE_FIELD_W-1:0] probes;
    } outcome_t;

    logic [KEY_W-1:0] held_key [TABLE_SLOTS];
    logic             occupied [TABLE_SLOTS];
    outcome_t         outcome_q [$];
    outcome_t         want;

    function automatic outcome_t probe_table(input logic [REQ_W-1:0] req_type,
                                             input logic [KEY_W-1:0] key);
        outcome_t o;
        int       idx;
        o.status = ST_CLEARED;
        o.slot   = '0;
        o.probes = '0;
        if (req_type[REQ_CLEAR_BIT])
        begin
            for (int s = 0; s < TABLE_SLOTS; s++)
                occupied[s] = 1'b0;
            return o;
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            idx = (int'(key % TABLE_SLOTS) + i) % TABLE_SLOTS;
            if (req_type == REQ_INSERT)
            begin
                if (!occupied[idx])
                begin
                    occupied[idx] = 1'b1;
                    held_key[idx] = key;
                    o.status      = ST_INSERTED;
                    o.slot        = SLOT_FIELD_W'(idx);
                    o.probes      = PROBE_FIELD_W'(i);
                    return o;
                end
            end
            else if (occupied[idx] && held_key[idx] == key)
            begin
                o.status = ST_FOUND;
                o.slot   = SLOT_FIELD_W'(idx);
                o.probes = PROBE_FIELD_W'(i);
                return o;
            end
        end
        if (req_type == REQ_INSERT)
            o.status = ST_FULL;
        else
            o.status = ST_ABSENT;
        o.probes = PROBE_FIELD_W'(TABLE_SLOTS);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_SLOTS; s++)
                occupied[s] = 1'b0;
            outcome_q.delete();
            pending = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                outcome_q.push_back(probe_table(req.req_type, req.key));
            if (res.valid && res.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result transaction with none pending: status %0d slot %0d probes %0d",
                                 $realtime, res.status, res.slot, res.probes);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (res.status !== want.status || res.slot !== want.slot ||
                        res.probes !== want.probes)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: expected status %0d slot %0d probes %0d, got status %0d slot %0d probes %0d",
                                     $realtime, want.status, want.slot, want.probes,
                                     res.status, res.slot, res.probes);
                        fail_count++;
                    end
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

>>> bench/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// drives inserts, searches and clears into the hash table with random gaps
// and result back-pressure, one long result stall, and a checker beside the
// block that predicts every result; prints the verdict at the end
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;

    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int               RANDOM_ITEMS  = 950;
    localparam int               CYCLE_LIMIT   = 400000;
    localparam int               DRAIN_CYCLES  = 40;
    localparam int               HOLD_CYCLES   = 300;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALT = 2'd3;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic hold_off = 1'b0;
    int   fail_count;
    int   pending;
    int   items_sent    = 0;
    int   results_taken = 0;
    int   cycle_count   = 0;

    lpht_req_if req_ch ();
    lpht_res_if res_ch ();

    linear_probe_hash_table i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    lpht_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic offer_request(input logic [REQ_W-1:0] req_type,
                                 input logic [KEY_W-1:0] key);
        int gap;
        gap = (items_sent % 60 >= 45) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req_type;
        req_ch.key      <= key;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // result side back-pressure
    initial
    begin
        int gap;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = (results_taken % 50 >= 35) ? 0 : $urandom_range(0, 11);
            if (gap > 0 || hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            results_taken++;
        end
    end

    // long result stall so the request side backs up
    initial
    begin
        wait (items_sent >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [KEY_W-SLOT_W-1:0] key_hi [4];
        logic [KEY_W-1:0]        key;
        int                      pick;

        req_ch.valid    <= 1'b0;
        req_ch.req_type <= OP_INSERT;
        req_ch.key      <= '0;
        key_hi[0] = '0;
        key_hi[1] = '1;
        key_hi[2] = (KEY_W-SLOT_W)'($urandom);
        key_hi[3] = (KEY_W-SLOT_W)'($urandom);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every slot once, with wrap-around and duplicate keys, insert into the full table, then search and clear
        offer_request(OP_INSERT, '1);
        offer_request(OP_INSERT, '0);
        offer_request(OP_INSERT, '1);
        offer_request(OP_INSERT, 31'd16);
        for (int s = 3; s < TABLE_SLOTS - 1; s++)
            offer_request(OP_INSERT, {27'h5555555, SLOT_W'(s)});
        offer_request(OP_INSERT, 31'h2aaaaaaa);
        offer_request(OP_SEARCH, '1);
        offer_request(OP_SEARCH, 31'd16);
        offer_request(OP_SEARCH, 31'h40000000);
        offer_request(OP_CLEAR, '0);
        offer_request(OP_SEARCH, '0);
        offer_request(OP_INSERT, 31'd15);
        offer_request(REQ_CLEAR_ALT, '1);
        offer_request(OP_SEARCH, 31'd15);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                key = KEY_W'($urandom);
            else
                key = {key_hi[$urandom_range(0, 3)], SLOT_W'($urandom_range(0, TABLE_SLOTS - 1))};
            if (pick < 2)
                offer_request(OP_CLEAR, key);
            else if (pick < 4)
                offer_request(REQ_CLEAR_ALT, key);
            else if (pick < 50)
                offer_request(OP_INSERT, key);
            else
                offer_request(OP_SEARCH, key);
        end
        req_ch.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
